>>> rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// Membership message parser package
// Item types, item kinds, end status codes and parse phases shared by the
// parser RTL.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Input item: one message byte and the last-byte marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [2:0]  item_kind;
    logic [31:0] item_value;
    logic [3:0]  end_status;
    logic        end_of_message;
  } out_t;

  // Item kinds.
  localparam logic [2:0] KIND_SENDER   = 3'd0;
  localparam logic [2:0] KIND_FAILED   = 3'd1;
  localparam logic [2:0] KIND_LEFT     = 3'd2;
  localparam logic [2:0] KIND_HOSTNAME = 3'd3;
  localparam logic [2:0] KIND_JOINED   = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  // End status codes.
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_SHORT_SENDER = 4'd1;
  localparam logic [3:0] ST_SHORT_TAG    = 4'd2;
  localparam logic [3:0] ST_BAD_TAG0     = 4'd3;
  localparam logic [3:0] ST_SHORT_COUNT  = 4'd6;
  localparam logic [3:0] ST_SHORT_NAMELEN = 4'd7;
  localparam logic [3:0] ST_SHORT_NAME   = 4'd8;
  localparam logic [3:0] ST_SHORT_ID     = 4'd9;
  localparam logic [3:0] ST_LEFTOVER     = 4'd10;
  localparam logic [3:0] ST_ZERO_SENDER  = 4'd11;

  // List tags.
  localparam logic [7:0] TAG_L = 8'h4C;
  localparam logic [7:0] TAG_J = 8'h4A;

  // Index of the joined list.
  localparam logic [1:0] LIST_JOINED = 2'd2;

  // Result queue size: room for the two results one byte can produce,
  // plus slack so that a byte can be taken every cycle while the result side takes items.
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;
  localparam int RES_CW    = 3;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_SENDER  = 7'b0000001,
    PH_TAG     = 7'b0000010,
    PH_COUNT   = 7'b0000100,
    PH_NAMELEN = 7'b0001000,
    PH_NAME    = 7'b0010000,
    PH_ID      = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

endpackage

>>> rtl/membership_message_parser_top.sv
// ----------------------------------------------------------------------------
// Membership message parser
// Parses a membership message one byte per item and emits the sender id,
// every list id, every hostname byte and an end item with a status.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                       | Direction | Payload
//  --------+-----------------------------+-----------+---------------------
//  input   | in_valid, in_ready, in_data | into      | data_byte, final_byte
//  result  | out_valid, out_ready,       | out of    | item_kind, item_value,
//          | out_data                    |           | end_status, end_of_message
//
//  One byte is parsed in the cycle it is accepted; its results (at most a
//  data item and an end item) are registered into a four-entry result queue
//  and leave it in order on the result port, one per cycle while out_ready is high.
//  A byte is accepted whenever the queue has room for two results, so with
//  the result side taking items a byte is accepted every cycle.
//  Reset (rst_n low, synchronous) returns the parser to the start of a
//  message and empties the queue. A stalled result side fills the queue and
//  then holds off input.
//
module membership_message_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mmp_pkg::out_t out_data
);
  import mmp_pkg::*;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  list_r, list_nxt;
  logic [31:0] entries_r, entries_nxt;
  logic [7:0]  name_rem_r, name_rem_nxt;
  logic        sender_nz_r, sender_nz_nxt;
  logic [3:0]  err_r, err_nxt;

  // Result queue.
  out_t              res_mem_r [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CW-1:0] count_r, count_nxt;

  logic        in_acc;
  logic        pop;
  logic        data_push, end_push;
  out_t        data_res, end_res;
  logic [31:0] word_full;
  logic [7:0]  tag_want;
  logic [3:0]  status;

  assign in_ready  = (count_r <= RES_CW'(RES_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = res_mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Word under assembly with the current byte placed, little-endian.
  assign word_full = word_r | ({24'd0, in_data.data_byte} << {byte_pos_r, 3'b000});
  assign tag_want  = (list_r == LIST_JOINED) ? TAG_J : TAG_L;

  // Parse one byte and form its results.
  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    word_nxt      = word_r;
    list_nxt      = list_r;
    entries_nxt   = entries_r;
    name_rem_nxt  = name_rem_r;
    sender_nz_nxt = sender_nz_r;
    err_nxt       = err_r;
    data_push     = 1'b0;
    end_push      = 1'b0;
    data_res      = '0;
    end_res       = '0;
    status        = ST_OK;

    if (in_acc) begin
      // Bytes after an error are ignored until the final byte.
      if (err_r == ST_OK) begin
        case (phase_r)
          PH_SENDER: begin
            word_nxt     = word_full;
            byte_pos_nxt = byte_pos_r + 2'd1;
            if (byte_pos_r == 2'd3) begin
              sender_nz_nxt       = (word_full != '0);
              data_push           = 1'b1;
              data_res.item_kind  = KIND_SENDER;
              data_res.item_value = word_full;
              word_nxt            = '0;
              phase_nxt           = PH_TAG;
            end
          end
          PH_TAG: begin
            if (in_data.data_byte != tag_want) begin
              err_nxt = ST_BAD_TAG0 + {2'b00, list_r};
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            word_nxt     = word_full;
            byte_pos_nxt = byte_pos_r + 2'd1;
            if (byte_pos_r == 2'd3) begin
              entries_nxt = word_full;
              word_nxt    = '0;
              if (word_full == '0) begin
                // Empty list: straight on to the next tag, or to the end after the joined list.
                if (list_r == LIST_JOINED) begin
                  phase_nxt = PH_DONE;
                end else begin
                  list_nxt  = list_r + 2'd1;
                  phase_nxt = PH_TAG;
                end
              end else begin
                phase_nxt = (list_r == LIST_JOINED) ? PH_NAMELEN : PH_ID;
              end
            end
          end
          PH_NAMELEN: begin
            name_rem_nxt = in_data.data_byte;
            phase_nxt    = (in_data.data_byte == '0) ? PH_ID : PH_NAME;
          end
          PH_NAME: begin
            data_push           = 1'b1;
            data_res.item_kind  = KIND_HOSTNAME;
            data_res.item_value = {24'd0, in_data.data_byte};
            name_rem_nxt        = name_rem_r - 8'd1;
            if (name_rem_r == 8'd1) begin
              phase_nxt = PH_ID;
            end
          end
          PH_ID: begin
            word_nxt     = word_full;
            byte_pos_nxt = byte_pos_r + 2'd1;
            if (byte_pos_r == 2'd3) begin
              data_push           = 1'b1;
              data_res.item_value = word_full;
              if (list_r == 2'd0) begin
                data_res.item_kind = KIND_FAILED;
              end else if (list_r == 2'd1) begin
                data_res.item_kind = KIND_LEFT;
              end else begin
                data_res.item_kind = KIND_JOINED;
              end
              word_nxt    = '0;
              entries_nxt = entries_r - 32'd1;
              if (entries_r == 32'd1) begin
                if (list_r == LIST_JOINED) begin
                  phase_nxt = PH_DONE;
                end else begin
                  list_nxt  = list_r + 2'd1;
                  phase_nxt = PH_TAG;
                end
              end else begin
                phase_nxt = (list_r == LIST_JOINED) ? PH_NAMELEN : PH_ID;
              end
            end
          end
          default: begin
            // Bytes after the joined list.
            err_nxt = ST_LEFTOVER;
          end
        endcase
      end

      // End of message: work out the status and start afresh.
      if (in_data.final_byte) begin
        status = err_nxt;
        if (status == ST_OK) begin
          case (phase_nxt)
            PH_SENDER:  status = ST_SHORT_SENDER;
            PH_TAG:     status = ST_SHORT_TAG;
            PH_COUNT:   status = ST_SHORT_COUNT;
            PH_NAMELEN: status = ST_SHORT_NAMELEN;
            PH_NAME:    status = ST_SHORT_NAME;
            PH_ID:      status = ST_SHORT_ID;
            default:    status = ST_OK;
          endcase
        end
        if ((status == ST_OK) && !sender_nz_nxt) begin
          status = ST_ZERO_SENDER;
        end
        end_push               = 1'b1;
        end_res.item_kind      = KIND_END;
        end_res.end_status     = status;
        end_res.end_of_message = 1'b1;

        phase_nxt     = PH_SENDER;
        byte_pos_nxt  = '0;
        word_nxt      = '0;
        list_nxt      = '0;
        entries_nxt   = '0;
        name_rem_nxt  = '0;
        sender_nz_nxt = 1'b0;
        err_nxt       = ST_OK;
      end
    end
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_AW'(data_push) + RES_AW'(end_push);
    rd_ptr_nxt = rd_ptr_r + RES_AW'(pop);
    count_nxt  = count_r + RES_CW'(data_push) + RES_CW'(end_push) - RES_CW'(pop);
  end

  // Control and parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SENDER;
      byte_pos_r  <= '0;
      word_r      <= '0;
      list_r      <= '0;
      entries_r   <= '0;
      name_rem_r  <= '0;
      sender_nz_r <= 1'b0;
      err_r       <= ST_OK;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      byte_pos_r  <= byte_pos_nxt;
      word_r      <= word_nxt;
      list_r      <= list_nxt;
      entries_r   <= entries_nxt;
      name_rem_r  <= name_rem_nxt;
      sender_nz_r <= sender_nz_nxt;
      err_r       <= err_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
    end
  end

  // Result storage: the data item first, then the end item behind it.
  always_ff @(posedge clk) begin
    if (data_push) begin
      res_mem_r[wr_ptr_r] <= data_res;
    end
    if (end_push) begin
      res_mem_r[wr_ptr_r + RES_AW'(data_push)] <= end_res;
    end
  end

`ifndef ASSERT_OFF
  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RES_CW'(RES_DEPTH))
    else $error("result queue overfilled");

  // A final byte always leaves the parser at the start of a message.
  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.final_byte) |=>
      (phase_r == PH_SENDER) && (err_r == ST_OK) && (byte_pos_r == '0))
    else $error("parser not restarted after final byte");

  // A latched error holds until the message ends.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r != ST_OK) && !(in_acc && in_data.final_byte)) |=> $stable(err_r))
    else $error("latched error changed inside a message");

  // The fill count follows the pushes and pops.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) + RES_CW'($past(data_push))
                   + RES_CW'($past(end_push)) - RES_CW'($past(pop))))
    else $error("result queue count out of step");
`endif

endmodule
